FILE: rtl/core/xtsl_pkg.sv
// Shared types and constants for the XML tag span locator.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package xtsl_pkg;

    // Parameter defaults
    localparam int MAX_TAG_CHARS_DEF = 8;
    localparam int POSITION_BITS_DEF = 24;
    localparam int DEPTH_BITS_DEF    = 16;

    // Fixed widths of the port fields
    localparam int FIELD_BITS     = 24;
    localparam int TAG_CHAR_BITS  = 64;
    localparam int TAG_LEN_BITS   = 4;
    localparam int CFG_INDEX_BITS = 2;

    // Characters of the tag syntax
    localparam logic [7:0] CHAR_LT    = 8'h3C;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_GT    = 8'h3E;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TAG_CHARS   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TAG_LENGTH  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SCOPE_START = 2'd2;

    typedef logic [FIELD_BITS-1:0] field_pos_t;

    // One input item: a scope byte and its end marker
    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } byte_item_t;

    // One result item
    typedef struct packed {
        logic       found;
        field_pos_t open_position;
        field_pos_t content_position;
        field_pos_t close_position;
    } span_result_t;

    // Configuration register contents
    typedef struct packed {
        logic [TAG_CHAR_BITS-1:0] tag_chars;
        logic [TAG_LEN_BITS-1:0]  tag_length;
        field_pos_t               scope_start;
    } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/xtsl_cfg.sv
// Configuration registers of the tag span locator.
// Depends on xtsl_pkg for the register indexes and the cfg_t bundle.
`default_nettype none

module xtsl_cfg (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [xtsl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [xtsl_pkg::TAG_CHAR_BITS-1:0]  cfg_data,
    output xtsl_pkg::cfg_t                          cfg
);

    xtsl_pkg::cfg_t cfg_reg;
    xtsl_pkg::cfg_t cfg_next;

    // Writes are always taken
    assign cfg_ready = 1'b1;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                xtsl_pkg::CFG_TAG_CHARS:
                begin
                    cfg_next.tag_chars = cfg_data;
                end
                xtsl_pkg::CFG_TAG_LENGTH:
                begin
                    cfg_next.tag_length = cfg_data[xtsl_pkg::TAG_LEN_BITS-1:0];
                end
                xtsl_pkg::CFG_SCOPE_START:
                begin
                    cfg_next.scope_start = cfg_data[xtsl_pkg::FIELD_BITS-1:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tag_chars   <= '0;
            cfg_reg.tag_length  <= xtsl_pkg::TAG_LEN_BITS'(1);
            cfg_reg.scope_start <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: rtl/core/xtsl_in_reg.sv
// Input register of the tag span locator: holds one byte item for the scanner.
// Depends on xtsl_pkg for the byte_item_t type.
`default_nettype none

module xtsl_in_reg (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 byte_valid,
    output logic                      byte_stall,
    input  wire xtsl_pkg::byte_item_t byte_item,
    input  wire logic                 take,
    output logic                      held_valid,
    output xtsl_pkg::byte_item_t      held_item
);

    logic                 valid_reg;
    logic                 valid_next;
    xtsl_pkg::byte_item_t item_reg;
    xtsl_pkg::byte_item_t item_next;
    logic                 accept;

    // Stall only while a held item is not taken this cycle
    assign byte_stall = valid_reg && !take;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (accept)
        begin
            valid_next = 1'b1;
            item_next  = byte_item;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

`default_nettype wire

FILE: rtl/core/xtsl_scan.sv
// Scanner of the tag span locator: look-ahead byte window, nesting depth,
// open/close tag compare and result build. Depends on xtsl_pkg.
`default_nettype none

module xtsl_scan #(
    parameter int MAX_TAG_CHARS = xtsl_pkg::MAX_TAG_CHARS_DEF,
    parameter int POSITION_BITS = xtsl_pkg::POSITION_BITS_DEF,
    parameter int DEPTH_BITS    = xtsl_pkg::DEPTH_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire xtsl_pkg::cfg_t       cfg,
    input  wire logic                 item_valid,
    input  wire xtsl_pkg::byte_item_t item,
    output logic                      item_take,
    input  wire logic                 res_space,
    output logic                      res_push,
    output xtsl_pkg::span_result_t    res
);

    localparam int WIN_LEN = MAX_TAG_CHARS + 3;
    localparam int PW      = $clog2(WIN_LEN + 1);

    typedef logic [POSITION_BITS-1:0] pos_t;
    typedef logic [PW-1:0]            cnt_t;
    typedef logic [DEPTH_BITS-1:0]    depth_t;

    typedef enum logic [2:0] {
        PH_OPEN  = 3'b001,
        PH_CLOSE = 3'b010,
        PH_DONE  = 3'b100
    } phase_t;

    localparam cnt_t WIN_FULL = cnt_t'(WIN_LEN);
    localparam cnt_t WIN_LAST = cnt_t'(WIN_LEN - 1);
    localparam cnt_t CNT_ONE  = cnt_t'(1);
    localparam cnt_t CNT_TWO  = cnt_t'(2);
    localparam cnt_t CNT_THR  = cnt_t'(3);

    // State
    logic [7:0] win_reg [WIN_LEN];
    logic [7:0] win_next [WIN_LEN];
    cnt_t       pend_reg,  pend_next;
    pos_t       count_reg, count_next;
    depth_t     depth_reg, depth_next;
    phase_t     phase_reg, phase_next;
    pos_t       held_reg,  held_next;
    cnt_t       skip_reg,  skip_next;
    pos_t       close_reg, close_next;
    logic       hit_reg,   hit_next;
    logic       drain_reg, drain_next;

    // Judge unit inputs
    logic [7:0] win_app [WIN_LEN];
    logic [7:0] jwin [WIN_LEN];
    cnt_t       jpend;
    pos_t       jpos;
    pos_t       count_inc;
    logic       judge_en;

    cnt_t             tag_n;
    logic [7:0]       tag_byte [WIN_LEN];
    logic [WIN_LEN-1:0] open_ok;
    logic [WIN_LEN-1:0] close_ok;
    logic             match_open;
    logic             match_close;
    logic             next_slash;
    logic             hit_now;
    logic             drain_end;

    pos_t scope_pos;
    pos_t open_abs;
    pos_t content_abs;
    pos_t close_abs;

    // Tag length clamp: zero acts as one, large values saturate
    always_comb
    begin
        if (cfg.tag_length == '0)
        begin
            tag_n = CNT_ONE;
        end
        else if (cfg.tag_length > xtsl_pkg::TAG_LEN_BITS'(MAX_TAG_CHARS))
        begin
            tag_n = cnt_t'(MAX_TAG_CHARS);
        end
        else
        begin
            tag_n = cnt_t'(cfg.tag_length);
        end
    end

    // Tag characters as a byte array, zero past the maximum length
    for (genvar j = 0; j < WIN_LEN; j++)
    begin : g_tag
        if (j < MAX_TAG_CHARS)
        begin : g_used
            assign tag_byte[j] = cfg.tag_chars[8*j +: 8];
        end
        else
        begin : g_pad
            assign tag_byte[j] = 8'h00;
        end
    end

    // Per-lane compare against "<tag>" and "</tag>"
    for (genvar i = 0; i < WIN_LEN; i++)
    begin : g_lane
        localparam cnt_t IDX = cnt_t'(i);
        logic [7:0] pat_o;
        logic [7:0] pat_c;

        if (i == 0)
        begin : g_first
            assign pat_o = xtsl_pkg::CHAR_LT;
            assign pat_c = xtsl_pkg::CHAR_LT;
        end
        else if (i == 1)
        begin : g_second
            assign pat_o = (IDX <= tag_n) ? tag_byte[i-1] : xtsl_pkg::CHAR_GT;
            assign pat_c = xtsl_pkg::CHAR_SLASH;
        end
        else
        begin : g_rest
            assign pat_o = (IDX <= tag_n) ? tag_byte[i-1] : xtsl_pkg::CHAR_GT;
            assign pat_c = (IDX <= tag_n + CNT_ONE) ? tag_byte[i-2] : xtsl_pkg::CHAR_GT;
        end

        assign open_ok[i]  = (IDX > tag_n + CNT_ONE) || (jwin[i] == pat_o);
        assign close_ok[i] = (IDX > tag_n + CNT_TWO) || (jwin[i] == pat_c);
    end

    // Judge source: appended window on the byte path, held window while draining
    always_comb
    begin
        for (int i = 0; i < WIN_LEN; i++)
        begin
            win_app[i] = (cnt_t'(i) == pend_reg) ? item.byte_value : win_reg[i];
            jwin[i]    = drain_reg ? win_reg[i] : win_app[i];
        end
        item_take = item_valid && !drain_reg && res_space;
        count_inc = count_reg + pos_t'(1);
        jpend     = drain_reg ? pend_reg : WIN_FULL;
        jpos      = drain_reg ? (count_reg - pos_t'(pend_reg))
                              : (count_inc - pos_t'(WIN_LEN));
        judge_en  = drain_reg ? res_space
                              : (item_take && !item.last_byte && (pend_reg == WIN_LAST));
    end

    assign match_open  = (&open_ok) && ((tag_n + CNT_TWO) <= jpend);
    assign match_close = (&close_ok) && ((tag_n + CNT_THR) <= jpend);
    assign next_slash  = (jpend >= CNT_TWO) && (jwin[1] == xtsl_pkg::CHAR_SLASH);
    assign drain_end   = drain_reg && res_space && (pend_reg == CNT_ONE);

    // Result positions; a close seen earlier in the flush is held in close_reg
    assign scope_pos   = pos_t'(cfg.scope_start);
    assign open_abs    = scope_pos + held_reg;
    assign content_abs = open_abs + pos_t'(tag_n) + pos_t'(2);
    assign close_abs   = scope_pos + (hit_reg ? close_reg : jpos);

    // Next state: append, judge the oldest byte, emit, clear at scope end
    always_comb
    begin
        for (int i = 0; i < WIN_LEN; i++)
        begin
            win_next[i] = win_reg[i];
        end
        pend_next  = pend_reg;
        count_next = count_reg;
        depth_next = depth_reg;
        phase_next = phase_reg;
        held_next  = held_reg;
        skip_next  = skip_reg;
        close_next = close_reg;
        hit_next   = hit_reg;
        drain_next = drain_reg;
        hit_now    = 1'b0;
        res_push   = 1'b0;
        res        = '0;

        // new byte enters the window
        if (item_take)
        begin
            for (int i = 0; i < WIN_LEN; i++)
            begin
                win_next[i] = win_app[i];
            end
            pend_next  = pend_reg + CNT_ONE;
            count_next = count_inc;
            if (item.last_byte)
            begin
                drain_next = 1'b1;
            end
        end

        // oldest byte is judged and shifted out
        if (judge_en)
        begin
            for (int i = 0; i < WIN_LEN - 1; i++)
            begin
                win_next[i] = jwin[i+1];
            end
            win_next[WIN_LEN-1] = 8'h00;
            pend_next = jpend - CNT_ONE;

            if (phase_reg != PH_DONE)
            begin
                if ((phase_reg == PH_CLOSE) && (skip_reg != '0))
                begin
                    // inside the open tag's own bytes
                    skip_next = skip_reg - CNT_ONE;
                end
                else if (jwin[0] == xtsl_pkg::CHAR_LT)
                begin
                    if ((depth_reg == '0) && (phase_reg == PH_OPEN) && match_open)
                    begin
                        phase_next = PH_CLOSE;
                        held_next  = jpos;
                        skip_next  = tag_n + CNT_ONE;
                    end
                    else if ((depth_reg == '0) && (phase_reg == PH_CLOSE) && match_close)
                    begin
                        phase_next = PH_DONE;
                        close_next = jpos;
                        hit_now    = 1'b1;
                    end
                    else if (next_slash)
                    begin
                        depth_next = depth_reg - depth_t'(1);
                    end
                    else
                    begin
                        depth_next = depth_reg + depth_t'(1);
                    end
                end
            end
        end

        // found result for a close judged mid-scope
        if (hit_now && !drain_reg)
        begin
            res_push              = 1'b1;
            res.found             = 1'b1;
            res.open_position     = xtsl_pkg::field_pos_t'(open_abs);
            res.content_position  = xtsl_pkg::field_pos_t'(content_abs);
            res.close_position    = xtsl_pkg::field_pos_t'(close_abs);
        end

        if (drain_end)
        begin
            // scope end: report a result not yet given and return to the start state
            if (hit_now || hit_reg)
            begin
                res_push              = 1'b1;
                res.found             = 1'b1;
                res.open_position     = xtsl_pkg::field_pos_t'(open_abs);
                res.content_position  = xtsl_pkg::field_pos_t'(content_abs);
                res.close_position    = xtsl_pkg::field_pos_t'(close_abs);
            end
            else if (phase_next != PH_DONE)
            begin
                res_push = 1'b1;
            end
            for (int i = 0; i < WIN_LEN; i++)
            begin
                win_next[i] = 8'h00;
            end
            pend_next  = '0;
            count_next = '0;
            depth_next = '0;
            phase_next = PH_OPEN;
            held_next  = '0;
            skip_next  = '0;
            close_next = '0;
            hit_next   = 1'b0;
            drain_next = 1'b0;
        end
        else if (drain_reg && hit_now)
        begin
            hit_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_LEN; i++)
            begin
                win_reg[i] <= 8'h00;
            end
            pend_reg  <= '0;
            count_reg <= '0;
            depth_reg <= '0;
            phase_reg <= PH_OPEN;
            held_reg  <= '0;
            skip_reg  <= '0;
            close_reg <= '0;
            hit_reg   <= 1'b0;
            drain_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < WIN_LEN; i++)
            begin
                win_reg[i] <= win_next[i];
            end
            pend_reg  <= pend_next;
            count_reg <= count_next;
            depth_reg <= depth_next;
            phase_reg <= phase_next;
            held_reg  <= held_next;
            skip_reg  <= skip_next;
            close_reg <= close_next;
            hit_reg   <= hit_next;
            drain_reg <= drain_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/xtsl_out_buf.sv
// Two-entry result buffer of the tag span locator, decoupling the result
// stall from the scanner. Depends on xtsl_pkg for span_result_t.
`default_nettype none

module xtsl_out_buf (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire xtsl_pkg::span_result_t push_item,
    output logic                        space,
    output logic                        span_valid,
    input  wire logic                   span_stall,
    output xtsl_pkg::span_result_t      span_result
);

    localparam logic [1:0] ENTRIES = 2'd2;

    logic [1:0]             cnt_reg,  cnt_next;
    xtsl_pkg::span_result_t head_reg, head_next;
    xtsl_pkg::span_result_t tail_reg, tail_next;
    logic                   pop;

    assign span_valid  = (cnt_reg != 2'd0);
    assign span_result = head_reg;
    assign pop         = span_valid && !span_stall;
    assign space       = (cnt_reg < ENTRIES);

    // Head/tail update
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
        if (pop)
        begin
            head_next = tail_reg;
        end
        if (push)
        begin
            if ((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop))
            begin
                head_next = push_item;
            end
            else
            begin
                tail_next = push_item;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

`default_nettype wire

FILE: rtl/core/xml_tag_span_locator_unit.sv
// Top level of the XML tag span locator.
// Instantiates xtsl_cfg, xtsl_in_reg, xtsl_scan and xtsl_out_buf; uses xtsl_pkg.
`default_nettype none

// The block scans one scope of an XML document, one byte per item, and
// reports the first element at nesting depth zero whose open tag is "<tag>"
// (tag set by tag_chars and tag_length) with its matching "</tag>". Bytes are
// taken at one per cycle unless stalled: each byte is held in an input register
// and then enters the scanner's look-ahead window of MAX_TAG_CHARS+3 bytes.
// A byte is judged once it is the oldest byte of a full window, so a close
// tag is judged MAX_TAG_CHARS+2 bytes after its '<' arrives; a result is
// written into a two-entry output buffer at the judging edge and is offered
// from the buffer's head. After the byte marked last_byte the input stalls
// while the bytes left in the window (up to MAX_TAG_CHARS+3) are judged, one
// byte per cycle while the buffer has room; the scope's found or not-found
// result, unless given earlier, comes when that flush ends. The input also
// stalls while the output buffer is full. A close tag found mid-scope gives
// its result at once; later bytes of the scope are then ignored. Configuration
// writes are always accepted and must only be made while the block is idle.
module xml_tag_span_locator_unit #(
    parameter int MAX_TAG_CHARS = xtsl_pkg::MAX_TAG_CHARS_DEF,
    parameter int POSITION_BITS = xtsl_pkg::POSITION_BITS_DEF,
    parameter int DEPTH_BITS    = xtsl_pkg::DEPTH_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // byte channel
    input  wire logic                                byte_valid,
    output logic                                     byte_stall,
    input  wire xtsl_pkg::byte_item_t                byte_item,
    // result channel
    output logic                                     span_valid,
    input  wire logic                                span_stall,
    output xtsl_pkg::span_result_t                   span_result,
    // configuration write channel
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [xtsl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [xtsl_pkg::TAG_CHAR_BITS-1:0]  cfg_data
);

    xtsl_pkg::cfg_t         cfg;
    logic                   held_valid;
    xtsl_pkg::byte_item_t   held_item;
    logic                   take;
    logic                   space;
    logic                   push;
    xtsl_pkg::span_result_t push_item;

    // Configuration registers
    xtsl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register
    xtsl_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .take       (take),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    // Window, depth tracking and tag match
    xtsl_scan #(
        .MAX_TAG_CHARS (MAX_TAG_CHARS),
        .POSITION_BITS (POSITION_BITS),
        .DEPTH_BITS    (DEPTH_BITS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (held_valid),
        .item       (held_item),
        .item_take  (take),
        .res_space  (space),
        .res_push   (push),
        .res        (push_item)
    );

    // Result buffer
    xtsl_out_buf u_out_buf (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_item   (push_item),
        .space       (space),
        .span_valid  (span_valid),
        .span_stall  (span_stall),
        .span_result (span_result)
    );

endmodule

`default_nettype wire
